FILE: rtl/core/abavg_pkg.sv
// abavg_pkg: shared constants, codes and types of the block averager
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package abavg_pkg;

  // converter word and code layout
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned CODE_BITS = 12;
  localparam int unsigned CODE_LSB  = RAW_W - CODE_BITS;
  // divisor is 2^(CODE_BITS-8) * sample_size, the power of two folds into a shift
  localparam int unsigned DIV_SHIFT = CODE_BITS - 8;

  localparam int unsigned SUM_W  = 28;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned VOLT_W = 25;

  // microvolt scale of one summed code unit, before the divide
  localparam int unsigned MULT_W = 17;
  localparam logic [MULT_W-1:0] UV_SCALE = MULT_W'(78125);
  localparam int unsigned PROD_W = SUM_W + MULT_W;
  localparam int unsigned DIV_W  = PROD_W - DIV_SHIFT;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0]  MAX_QUOT  = DIV_W'(19999999);
  localparam logic [VOLT_W-1:0] OFFSET_UV = VOLT_W'(10000000);

  // queue between front and back, depth a power of two
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 1'b1;

  // input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FETCH  = 1'b1;

  typedef enum logic [1:0] {
    KIND_STROBE    = 2'd0,
    KIND_ANSWER    = 2'd1,
    KIND_NOT_READY = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // one queued job, classified by the front
  typedef struct packed {
    result_kind_e            kind;
    logic [CHAN_W-1:0]       chan;
    logic [SUM_W-1:0]        sum;
    logic [SIZE_W-1:0]       size;
    logic                    ovr;
  } job_t;

endpackage

FILE: rtl/core/abavg_front.sv
// abavg_front: config registers, sample accumulation, period end and fetch classification
// depends on abavg_pkg; pushes jobs into abavg_fifo
`timescale 1ns / 1ps

module abavg_front import abavg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [RAW_W-1:0]     raw_word_i,
  input  logic                 full_i,
  output logic                 push_o,
  output job_t                 push_data_o
);

  logic [SIZE_W-1:0] sample_size_q;
  logic [CHAN_W-1:0] channel_q;
  logic [SUM_W-1:0]  running_sum_q, running_sum_d;
  logic [SIZE_W-1:0] collected_q, collected_d;
  logic [SUM_W-1:0]  latched_q, latched_d;
  logic              taken_q, taken_d;
  logic              overrun_q, overrun_d;

  logic              accept;
  logic [SIZE_W-1:0] eff_size;
  logic [SUM_W-1:0]  sum_add;
  logic [SIZE_W:0]   coll_p1;
  logic              period_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign eff_size   = (sample_size_q == '0) ? SIZE_W'(1) : sample_size_q;
  assign sum_add    = running_sum_q + SUM_W'(raw_word_i[RAW_W-1:CODE_LSB]);
  assign coll_p1    = {1'b0, collected_q} + (SIZE_W+1)'(1);
  assign period_end = coll_p1 >= {1'b0, eff_size};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_size_q <= SIZE_W'(1);
      channel_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_SIZE: sample_size_q <= cfg_wdata_i;
        CFG_CHANNEL:     channel_q     <= cfg_wdata_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    running_sum_d = running_sum_q;
    collected_d   = collected_q;
    latched_d     = latched_q;
    taken_d       = taken_q;
    overrun_d     = overrun_q;
    push_o        = 1'b0;
    push_data_o   = '{kind: KIND_STROBE, chan: '0, sum: '0, size: eff_size, ovr: 1'b0};
    if (accept) begin
      if (func_i == FUNC_SAMPLE) begin
        if (period_end) begin
          overrun_d        = !taken_q;
          latched_d        = sum_add;
          taken_d          = 1'b0;
          running_sum_d    = '0;
          collected_d      = '0;
          push_o           = 1'b1;
          push_data_o.chan = channel_q;
        end else begin
          running_sum_d = sum_add;
          collected_d   = coll_p1[SIZE_W-1:0];
        end
      end else if (taken_q) begin
        push_o           = 1'b1;
        push_data_o.kind = KIND_NOT_READY;
      end else begin
        push_o           = 1'b1;
        push_data_o.kind = KIND_ANSWER;
        push_data_o.sum  = latched_q;
        push_data_o.ovr  = overrun_q;
        overrun_d        = 1'b0;
        taken_d          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      collected_q   <= '0;
      latched_q     <= '0;
      taken_q       <= 1'b1;
      overrun_q     <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      collected_q   <= collected_d;
      latched_q     <= latched_d;
      taken_q       <= taken_d;
      overrun_q     <= overrun_d;
    end
  end

  // a fetch always leaves the sum taken and the overrun cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_FETCH) |=> (taken_q && !overrun_q))
    else $error("fetch did not consume the latched sum");

  // a period end restarts the count and marks a fresh sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_SAMPLE && period_end) |=> (!taken_q && collected_q == '0))
    else $error("period end did not restart collection");

endmodule

FILE: rtl/core/abavg_fifo.sv
// abavg_fifo: short job queue between front and back
// depends on abavg_pkg for the job type and depth
`timescale 1ns / 1ps

module abavg_fifo import abavg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job pushed into a full queue");

endmodule

FILE: rtl/core/abavg_back.sv
// abavg_back: carries out queued jobs, scale multiply and bit-serial divide, result register
// depends on abavg_pkg; pops jobs from abavg_fifo
`timescale 1ns / 1ps

module abavg_back import abavg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  job_t                     job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               result_kind_o,
  output logic [CHAN_W-1:0]        strobe_channel_o,
  output logic signed [VOLT_W-1:0] voltage_uv_o,
  output logic                     overrun_o
);

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [DIV_W-1:0]  dq_q;
  logic [SIZE_W-1:0] rem_q;
  logic [STEP_W-1:0] step_q;

  logic              out_valid_q;
  result_kind_e      kind_q;
  logic [CHAN_W-1:0] chan_q;
  logic [VOLT_W-1:0] volt_q;
  logic              ovr_q;

  logic              out_free;
  logic              last_step;
  logic              load_simple, load_answer;
  logic [PROD_W-1:0] product;
  logic [SIZE_W:0]   rem_shift;
  logic              rem_ge;
  logic [VOLT_W-1:0] quot_sat;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = step_q == STEP_W'(DIV_W - 1);
  assign product   = PROD_W'(job_q.sum) * PROD_W'(UV_SCALE);
  assign rem_shift = {rem_q, dq_q[DIV_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, job_q.size};
  assign quot_sat  = (dq_q > MAX_QUOT) ? MAX_QUOT[VOLT_W-1:0] : dq_q[VOLT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (job_valid_i && job_i.kind == KIND_ANSWER) state_d = BK_MUL;
      BK_MUL:  state_d = BK_DIV;
      BK_DIV:  if (last_step) state_d = BK_DONE;
      BK_DONE: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o       = 1'b0;
    load_simple = 1'b0;
    load_answer = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == KIND_ANSWER) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            pop_o       = 1'b1;
            load_simple = 1'b1;
          end
        end
      end
      BK_DONE: load_answer = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath: multiply once, then one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && pop_o) begin
      job_q <= job_i;
    end
    if (state_q == BK_MUL) begin
      dq_q   <= product[PROD_W-1:DIV_SHIFT];
      rem_q  <= '0;
      step_q <= '0;
    end else if (state_q == BK_DIV) begin
      rem_q  <= rem_ge ? rem_shift[SIZE_W-1:0] - job_q.size : rem_shift[SIZE_W-1:0];
      dq_q   <= {dq_q[DIV_W-2:0], rem_ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_simple || load_answer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_simple) begin
      kind_q <= job_i.kind;
      chan_q <= job_i.chan;
      volt_q <= '0;
      ovr_q  <= 1'b0;
    end else if (load_answer) begin
      kind_q <= KIND_ANSWER;
      chan_q <= '0;
      volt_q <= quot_sat - OFFSET_UV;
      ovr_q  <= job_q.ovr;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign strobe_channel_o = chan_q;
  assign voltage_uv_o     = signed'(volt_q);
  assign overrun_o        = ovr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> (job_q.kind == KIND_ANSWER))
    else $error("divider busy on a job that needs no divide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV && last_step) |=> (state_q == BK_DONE))
    else $error("divide did not finish after its last step");

endmodule

FILE: rtl/core/adc_block_averager_with_overrun_unit.sv
// adc_block_averager_with_overrun_unit: top level of the converter block averager
// depends on abavg_pkg, abavg_front, abavg_fifo, abavg_back
`timescale 1ns / 1ps

// block averager for an offset-coded converter. a sample transaction (func 0) adds
// bits 15..4 of raw_word to the running sum; after sample_size samples the sum is
// latched, overrun is set if the previous sum was never fetched, and a strobe result
// carrying channel_number comes out. a fetch transaction (func 1) answers with the
// period mean in microvolts, floor(sum*78125/(16*sample_size)) - 10000000, saturated
// at 9999999, plus the overrun flag, which the fetch clears; with nothing fresh it
// answers not-ready without a divide. sample_size 0 acts as 1. samples are taken
// one per cycle while the queue is not full: a sample that ends no period yields no
// result, one that ends a period queues a strobe. a fetch answer is popped from
// the queue, passes the 28x17 scale multiply and the bit-serial divider, and is
// then loaded into the result register. a two-entry queue sits between the front
// and the back end, so samples keep flowing while a divide runs until two jobs wait.
// configuration: write enable, index 0 = sample_size, index 1 = channel_number.

module adc_block_averager_with_overrun_unit import abavg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [SIZE_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [RAW_W-1:0]         raw_word_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               result_kind_o,
  output logic [CHAN_W-1:0]        strobe_channel_o,
  output logic signed [VOLT_W-1:0] voltage_uv_o,
  output logic                     overrun_o
);

  // front to queue
  logic push;
  job_t push_data;
  logic full;

  // queue to back end
  logic pop;
  logic job_valid;
  job_t job;

  // front: holds all period state, so ordering of samples and fetches is exact
  abavg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .raw_word_i  (raw_word_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // job queue, each job carries its own snapshot of sum, size and overrun
  abavg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .data_o      (job)
  );

  // back end: scaling, divide and the result register
  abavg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_i            (job),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .strobe_channel_o (strobe_channel_o),
    .voltage_uv_o     (voltage_uv_o),
    .overrun_o        (overrun_o)
  );

endmodule
